// ===== src/fmpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpr_pkg
// Shared types, constants and breakpoint tables of the FM protection ratio
// interpolator.
// ----------------------------------------------------------------------------
package fmpr_pkg;

   // Input and output field widths.
   localparam int FREQ_W  = 18;
   localparam int SYS_W   = 3;
   localparam int LEVEL_W = 13;

   // Breakpoint grid: points spaced STEP_KHZ apart, starting at 0 kHz.
   localparam int TABLE_POINTS = 17;
   localparam int STEP_KHZ     = 25;
   localparam int SEG_LAST     = TABLE_POINTS - 2;
   localparam int FAR_KHZ      = STEP_KHZ * SEG_LAST;
   localparam int IDX_W        = $clog2(TABLE_POINTS);
   localparam int NEAR_W       = $clog2(FAR_KHZ);

   // Near offsets are divided by the step through a multiply by
   // NEAR_RECIP / 2**NEAR_SHIFT, exact for all offsets below FAR_KHZ.
   localparam int NEAR_RECIP  = 41;
   localparam int NEAR_SHIFT  = 10;
   localparam int NEAR_PROD_W = NEAR_W + 6;

   // Offset into the last segment is clamped; beyond this the result is
   // saturated in any case.
   localparam int REM_W   = 12;
   localparam int REM_MAX = (1 << REM_W) - 1;

   // Interpolation arithmetic widths.
   localparam int DIFF_W = LEVEL_W + 1;
   localparam int PROD_W = DIFF_W + REM_W + 1;
   localparam int NUM_W  = 20;

   // Floor division by the step: the numerator is biased positive, then
   // divided by a reciprocal multiply. The reciprocal is rounded up with
   // enough fraction bits that the quotient is exact over the whole biased
   // range, so the estimate is never high and never more than one low.
   localparam int DIV_OFFSET  = 8192;
   localparam int DIV_BIAS    = DIV_OFFSET * STEP_KHZ + (STEP_KHZ - 1) / 2;
   localparam int BIASED_W    = 19;
   localparam int RECIP       = 671089;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 24;
   localparam int RPROD_W     = BIASED_W + RECIP_W;
   localparam int QUOT_W      = RPROD_W - RECIP_SHIFT;
   localparam int REMD_W      = 6;
   localparam int SUM_W       = LEVEL_W + 4;

   localparam int PR_MIN = -4096;

   // System codes.
   localparam logic [SYS_W-1:0] SYS_MONO75       = 3'd1;
   localparam logic [SYS_W-1:0] SYS_MONO50       = 3'd2;
   localparam logic [SYS_W-1:0] SYS_STEREO50     = 3'd3;
   localparam logic [SYS_W-1:0] SYS_STEREO75     = 3'd4;
   localparam logic [SYS_W-1:0] SYS_STEREO50_ALT = 3'd5;

   // Table pair numbers; each pair holds a steady row then a tropo row.
   localparam logic [1:0] PAIR_MONO75   = 2'd0;
   localparam logic [1:0] PAIR_STEREO75 = 2'd1;
   localparam logic [1:0] PAIR_MONO50   = 2'd2;
   localparam logic [1:0] PAIR_STEREO50 = 2'd3;

   typedef logic signed [LEVEL_W-1:0] level_type;
   typedef logic [IDX_W-1:0]          seg_idx_type;

   // Protection ratios in 1/16 dB.
   localparam level_type PR_TAB [0:7][0:TABLE_POINTS-1] = '{
      '{576, 496, 384, 256, 192, 152, 128, 112, 96, 72, 32, -32, -112, -184, -240, -280, -320},
      '{448, 432, 352, 256, 192, 152, 128, 112, 96, 72, 32, -32, -112, -184, -240, -280, -320},
      '{720, 816, 816, 720, 528, 392, 288, 176, 112, 72, 32, -32, -112, -184, -240, -280, -320},
      '{592, 688, 688, 592, 400, 288, 224, 160, 112, 72, 32, -32, -112, -184, -240, -280, -320},
      '{624, 512, 384, 240, 192, 120, 96, 32, -40, -56, -96, -120, -160, -192, -240, -280, -320},
      '{512, 448, 352, 240, 192, 120, 96, 32, -40, -56, -96, -120, -160, -192, -240, -280, -320},
      '{784, 848, 816, 720, 528, 400, 288, 192, 112, 80, 32, 0, -112, -160, -240, -280, -320},
      '{656, 720, 688, 592, 400, 288, 224, 176, 112, 80, 32, 0, -112, -160, -240, -280, -320}
   };

   // Fields that ride along with an item through the pipeline.
   typedef struct packed {
      logic [SYS_W-1:0] system_code;
      level_type        median_field;
      level_type        usable_field;
   } side_type;

   // Segment number and offset within it.
   typedef struct packed {
      side_type         side;
      seg_idx_type      seg;
      logic [REM_W-1:0] rem_khz;
   } seg_type;

   // Both interpolated ratios.
   typedef struct packed {
      side_type  side;
      level_type steady;
      level_type tropo;
   } ratio_type;

   typedef struct packed {
      logic       known;
      logic [1:0] pair;
   } pair_sel_type;

   function automatic pair_sel_type sys_pair(input logic [SYS_W-1:0] code);
      pair_sel_type sel;
      sel.known = 1'b1;
      unique case (code)
         SYS_MONO75:       sel.pair = PAIR_MONO75;
         SYS_STEREO75:     sel.pair = PAIR_STEREO75;
         SYS_MONO50:       sel.pair = PAIR_MONO50;
         SYS_STEREO50:     sel.pair = PAIR_STEREO50;
         SYS_STEREO50_ALT: sel.pair = PAIR_STEREO50;
         default: begin
            sel.known = 1'b0;
            sel.pair  = PAIR_MONO75;
         end
      endcase
      return sel;
   endfunction

endpackage

// ===== src/fmpr_seg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpr_seg
// Two pipeline stages: carrier offset, then breakpoint segment and the
// offset into that segment.
// ----------------------------------------------------------------------------
module fmpr_seg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic [fmpr_pkg::FREQ_W-1:0]  in_wanted,
   input  logic [fmpr_pkg::FREQ_W-1:0]  in_interferer,
   input  fmpr_pkg::side_type           in_side,
   output logic                         out_valid,
   input  logic                         out_stall,
   output fmpr_pkg::seg_type            out_item
);
   import fmpr_pkg::*;

   logic              a_valid_ff, a_valid_in;
   logic [FREQ_W-1:0] a_off_ff, a_off_in;
   side_type          a_side_ff;
   logic              b_valid_ff, b_valid_in;
   seg_type           b_item_ff, b_item_in;
   logic              en_a, en_b;

   logic                   far;
   logic [NEAR_W-1:0]      near_off;
   logic [NEAR_PROD_W-1:0] near_prod;
   seg_idx_type            near_seg;
   logic [NEAR_W-1:0]      near_rem;
   logic [FREQ_W-1:0]      far_rem;

   assign en_b     = !b_valid_ff || !out_stall;
   assign en_a     = !a_valid_ff || en_b;
   assign in_stall = !en_a;

   // Stage A: absolute offset between the carriers.
   always_comb begin
      a_off_in   = (in_wanted >= in_interferer) ? (in_wanted - in_interferer)
                                                : (in_interferer - in_wanted);
      a_valid_in = en_a ? in_valid : a_valid_ff;
   end

   // Stage B: segment number by reciprocal multiply below the last segment;
   // at and beyond it the last segment is extrapolated.
   always_comb begin
      far       = a_off_ff >= FREQ_W'(FAR_KHZ);
      near_off  = a_off_ff[NEAR_W-1:0];
      near_prod = NEAR_PROD_W'(near_off) * NEAR_PROD_W'(NEAR_RECIP);
      near_seg  = near_prod[NEAR_SHIFT +: IDX_W];
      near_rem  = near_off - NEAR_W'(near_seg) * NEAR_W'(STEP_KHZ);
      far_rem   = a_off_ff - FREQ_W'(FAR_KHZ);

      b_item_in.side = a_side_ff;
      if (far) begin
         b_item_in.seg     = IDX_W'(SEG_LAST);
         b_item_in.rem_khz = (far_rem > FREQ_W'(REM_MAX)) ? REM_W'(REM_MAX)
                                                          : far_rem[REM_W-1:0];
      end else begin
         b_item_in.seg     = near_seg;
         b_item_in.rem_khz = REM_W'(near_rem);
      end
      b_valid_in = en_b ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_off_ff  <= a_off_in;
         a_side_ff <= in_side;
      end
      if (en_b) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

// ===== src/fmpr_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpr_interp
// Four pipeline stages that interpolate the steady and tropospheric ratios
// side by side: table lookup, slope multiply, reciprocal divide, rounding
// correction and saturation.
// ----------------------------------------------------------------------------
module fmpr_interp (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  fmpr_pkg::seg_type   in_item,
   output logic                out_valid,
   input  logic                out_stall,
   output fmpr_pkg::ratio_type out_item
);
   import fmpr_pkg::*;

   localparam int LANES = 2;

   logic en_c, en_d, en_e, en_f;
   logic c_valid_ff, d_valid_ff, e_valid_ff, f_valid_ff;

   // Stage C: table entries and slope.
   side_type                  c_side_ff;
   logic [REM_W-1:0]          c_rem_ff;
   level_type                 c_e0_ff   [LANES];
   logic signed [DIFF_W-1:0]  c_diff_ff [LANES];
   level_type                 c_e0_in   [LANES];
   logic signed [DIFF_W-1:0]  c_diff_in [LANES];

   // Stage D: slope times offset.
   side_type                  d_side_ff;
   level_type                 d_e0_ff  [LANES];
   logic signed [NUM_W-1:0]   d_num_ff [LANES];
   logic signed [NUM_W-1:0]   d_num_in [LANES];

   // Stage E: biased numerator and estimated quotient.
   side_type                  e_side_ff;
   level_type                 e_e0_ff     [LANES];
   logic [BIASED_W-1:0]       e_biased_ff [LANES];
   logic [QUOT_W-1:0]         e_quot_ff   [LANES];
   logic [BIASED_W-1:0]       e_biased_in [LANES];
   logic [QUOT_W-1:0]         e_quot_in   [LANES];

   // Stage F: finished ratios.
   ratio_type                 f_item_ff, f_item_in;
   level_type                 f_lvl_in [LANES];

   pair_sel_type              sel;
   seg_idx_type               seg_next;

   assign en_f     = !f_valid_ff || !out_stall;
   assign en_e     = !e_valid_ff || en_f;
   assign en_d     = !d_valid_ff || en_e;
   assign en_c     = !c_valid_ff || en_d;
   assign in_stall = !en_c;

   // Stage C: unknown systems read as an all-zero table.
   always_comb begin
      level_type e1;
      sel      = sys_pair(in_item.side.system_code);
      seg_next = in_item.seg + 1'b1;
      for (int lane = 0; lane < LANES; lane++) begin
         if (sel.known) begin
            c_e0_in[lane] = PR_TAB[{sel.pair, 1'(lane)}][in_item.seg];
            e1            = PR_TAB[{sel.pair, 1'(lane)}][seg_next];
         end else begin
            c_e0_in[lane] = '0;
            e1            = '0;
         end
         c_diff_in[lane] = DIFF_W'(e1) - DIFF_W'(c_e0_in[lane]);
      end
   end

   // Stage D.
   always_comb begin
      logic signed [PROD_W-1:0] prod;
      for (int lane = 0; lane < LANES; lane++) begin
         prod           = c_diff_ff[lane] * $signed({1'b0, c_rem_ff});
         d_num_in[lane] = prod[NUM_W-1:0];
      end
   end

   // Stage E: the bias moves the numerator positive and adds the rounding
   // half step, so a plain floor of the biased value gives the rounded result.
   always_comb begin
      logic signed [BIASED_W+1:0] biased;
      logic [RPROD_W-1:0]         rprod;
      for (int lane = 0; lane < LANES; lane++) begin
         biased            = (BIASED_W+2)'(d_num_ff[lane]) + (BIASED_W+2)'(DIV_BIAS);
         e_biased_in[lane] = biased[BIASED_W-1:0];
         rprod             = RPROD_W'(e_biased_in[lane]) * RPROD_W'(RECIP);
         e_quot_in[lane]   = rprod[RPROD_W-1:RECIP_SHIFT];
      end
   end

   // Stage F: the estimate is at most one low; fix it, remove the offset,
   // add the base entry and saturate at the floor.
   always_comb begin
      logic [BIASED_W-1:0]      remd_full;
      logic [REMD_W-1:0]        remd;
      logic [QUOT_W-1:0]        quot;
      logic signed [SUM_W-1:0]  sum;
      for (int lane = 0; lane < LANES; lane++) begin
         remd_full = e_biased_ff[lane] - BIASED_W'(e_quot_ff[lane]) * BIASED_W'(STEP_KHZ);
         remd      = remd_full[REMD_W-1:0];
         quot      = e_quot_ff[lane] + QUOT_W'(remd >= REMD_W'(STEP_KHZ));
         sum       = SUM_W'(e_e0_ff[lane]) + $signed(SUM_W'(quot)) - SUM_W'(DIV_OFFSET);
         f_lvl_in[lane] = (sum < SUM_W'(PR_MIN)) ? LEVEL_W'(PR_MIN) : sum[LEVEL_W-1:0];
      end
      f_item_in.side   = e_side_ff;
      f_item_in.steady = f_lvl_in[0];
      f_item_in.tropo  = f_lvl_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (en_c) c_valid_ff <= in_valid;
         if (en_d) d_valid_ff <= c_valid_ff;
         if (en_e) e_valid_ff <= d_valid_ff;
         if (en_f) f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_side_ff <= in_item.side;
         c_rem_ff  <= in_item.rem_khz;
         for (int lane = 0; lane < LANES; lane++) begin
            c_e0_ff[lane]   <= c_e0_in[lane];
            c_diff_ff[lane] <= c_diff_in[lane];
         end
      end
      if (en_d) begin
         d_side_ff <= c_side_ff;
         for (int lane = 0; lane < LANES; lane++) begin
            d_e0_ff[lane]  <= c_e0_ff[lane];
            d_num_ff[lane] <= d_num_in[lane];
         end
      end
      if (en_e) begin
         e_side_ff <= d_side_ff;
         for (int lane = 0; lane < LANES; lane++) begin
            e_e0_ff[lane]     <= d_e0_ff[lane];
            e_biased_ff[lane] <= e_biased_in[lane];
            e_quot_ff[lane]   <= e_quot_in[lane];
         end
      end
      if (en_f) begin
         f_item_ff <= f_item_in;
      end
   end

   assign out_valid = f_valid_ff;
   assign out_item  = f_item_ff;

endmodule

// ===== src/fm_protection_ratio_interp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_protection_ratio_interp_top
// FM broadcast protection ratio lookup with linear interpolation over the
// carrier offset and a choice between steady and tropospheric interference.
// ----------------------------------------------------------------------------
// The block accepts one transfer per clock cycle while the result side
// does not stall and returns one result per transfer, in order. The
// pipeline steps are carrier offset, segment search, table lookup, slope
// multiply, reciprocal divide by the 25 kHz step, rounding correction
// with saturation, and the final compare in the output register. Every
// stage carries its own valid bit, so bubbles are squeezed out and new
// transfers keep arriving while a finished result is held for the
// receiver. Ratios are in 1/16 dB; offsets beyond 400 kHz follow the
// last segment downward and saturate at -256 dB. System codes other
// than the five defined ones give ratios of zero.
// ----------------------------------------------------------------------------
module fm_protection_ratio_interp_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fmpr_pkg::FREQ_W-1:0]         req_wanted_freq_khz,
   input  logic [fmpr_pkg::FREQ_W-1:0]         req_interferer_freq_khz,
   input  logic [fmpr_pkg::SYS_W-1:0]          req_system_code,
   input  logic signed [fmpr_pkg::LEVEL_W-1:0] req_median_field,
   input  logic signed [fmpr_pkg::LEVEL_W-1:0] req_usable_field,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fmpr_pkg::LEVEL_W-1:0] rsp_protection_ratio,
   output logic                                rsp_chose_steady
);
   import fmpr_pkg::*;

   side_type   req_side;
   logic       seg_valid, seg_stall;
   seg_type    seg_item;
   logic       ratio_valid, ratio_stall;
   ratio_type  ratio_item;

   logic       out_valid_ff;
   level_type  out_ratio_ff, out_ratio_in;
   logic       out_steady_ff, out_steady_in;
   logic       en_out;

   assign req_side.system_code  = req_system_code;
   assign req_side.median_field = req_median_field;
   assign req_side.usable_field = req_usable_field;

   // Offset and segment.
   fmpr_seg u_seg (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_stall      (req_stall),
      .in_wanted     (req_wanted_freq_khz),
      .in_interferer (req_interferer_freq_khz),
      .in_side       (req_side),
      .out_valid     (seg_valid),
      .out_stall     (seg_stall),
      .out_item      (seg_item)
   );

   // Steady and tropospheric interpolation.
   fmpr_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_stall  (seg_stall),
      .in_item   (seg_item),
      .out_valid (ratio_valid),
      .out_stall (ratio_stall),
      .out_item  (ratio_item)
   );

   // The output register takes a new result whenever it is empty or its
   // current result is being transferred in this cycle.
   assign en_out      = !out_valid_ff || !rsp_stall;
   assign ratio_stall = !en_out;

   // The steady ratio wins when the median field plus the steady ratio is at
   // least the tropospheric ratio plus the usable field; a tie picks steady.
   always_comb begin
      logic signed [LEVEL_W:0] steady_margin;
      logic signed [LEVEL_W:0] tropo_margin;
      steady_margin = (LEVEL_W+1)'(ratio_item.side.median_field)
                    + (LEVEL_W+1)'(ratio_item.steady);
      tropo_margin  = (LEVEL_W+1)'(ratio_item.tropo)
                    + (LEVEL_W+1)'(ratio_item.side.usable_field);
      out_steady_in = steady_margin >= tropo_margin;
      out_ratio_in  = out_steady_in ? ratio_item.steady : ratio_item.tropo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en_out) begin
         out_valid_ff <= ratio_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         out_ratio_ff  <= out_ratio_in;
         out_steady_ff <= out_steady_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_protection_ratio = out_ratio_ff;
   assign rsp_chose_steady     = out_steady_ff;

endmodule

// ===== tb/sv/fm_protection_ratio_interp_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_protection_ratio_interp_top_tb
// Self-checking testbench for the FM protection ratio interpolator.
// Every accepted request is run through a local model of the BS.412 tables.
// The model finds the carrier offset, interpolates the steady and tropo
// ratios and makes the field strength comparison. The predicted ratio is
// queued and compared field by field with each result the block returns.
// Directed corner cases come first. Random phases with several idle and
// stall mixes follow, then a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module fm_protection_ratio_interp_top_tb;
   import fmpr_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 10;
   localparam int PIPE_DEPTH   = 7;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int FREQ_MAX     = (1 << FREQ_W) - 1;
   localparam int LEVEL_MAX    = (1 << (LEVEL_W - 1)) - 1;
   localparam int LEVEL_MIN    = -(1 << (LEVEL_W - 1));
   localparam int GRID_KHZ     = 25;
   localparam int LAST_SEG     = 15;
   localparam int RATIO_FLOOR  = -4096;
   localparam int MAX_PRINTED  = 40;

   // System codes that select no table; both ratios are zero for them.
   localparam logic [SYS_W-1:0] SYS_UNKNOWN_ZERO  = 3'd0;
   localparam logic [SYS_W-1:0] SYS_UNKNOWN_SIX   = 3'd6;
   localparam logic [SYS_W-1:0] SYS_UNKNOWN_SEVEN = 3'd7;

   // Row numbers into the local ratio table. Each system uses a steady row
   // and the tropospheric row right after it.
   localparam int ROW_NONE     = -1;
   localparam int ROW_MONO75   = 0;
   localparam int ROW_STEREO75 = 2;
   localparam int ROW_MONO50   = 4;
   localparam int ROW_STEREO50 = 6;

   // Our own copy of the breakpoint tables, in 1/16 dB, 0 to 400 kHz.
   localparam int RATIO_TAB [0:7][0:16] = '{
      '{576, 496, 384, 256, 192, 152, 128, 112, 96, 72, 32, -32, -112, -184, -240, -280,
        -320},
      '{448, 432, 352, 256, 192, 152, 128, 112, 96, 72, 32, -32, -112, -184, -240, -280,
        -320},
      '{720, 816, 816, 720, 528, 392, 288, 176, 112, 72, 32, -32, -112, -184, -240, -280,
        -320},
      '{592, 688, 688, 592, 400, 288, 224, 160, 112, 72, 32, -32, -112, -184, -240, -280,
        -320},
      '{624, 512, 384, 240, 192, 120, 96, 32, -40, -56, -96, -120, -160, -192, -240, -280,
        -320},
      '{512, 448, 352, 240, 192, 120, 96, 32, -40, -56, -96, -120, -160, -192, -240, -280,
        -320},
      '{784, 848, 816, 720, 528, 400, 288, 192, 112, 80, 32, 0, -112, -160, -240, -280,
        -320},
      '{656, 720, 688, 592, 400, 288, 224, 176, 112, 80, 32, 0, -112, -160, -240, -280,
        -320}
   };

   // One pair of carriers with its system and field strengths.
   typedef struct {
      logic [FREQ_W-1:0] wanted;
      logic [FREQ_W-1:0] interferer;
      logic [SYS_W-1:0]  system_code;
      level_type         median;
      level_type         usable;
   } carrier_pair_type;

   // The ratio the block should return for one pair.
   typedef struct {
      level_type ratio;
      logic      steady;
   } ratio_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [FREQ_W-1:0]       req_wanted_freq_khz = '0;
   logic [FREQ_W-1:0]       req_interferer_freq_khz = '0;
   logic [SYS_W-1:0]        req_system_code = '0;
   logic signed [LEVEL_W-1:0] req_median_field = '0;
   logic signed [LEVEL_W-1:0] req_usable_field = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [LEVEL_W-1:0] rsp_protection_ratio;
   logic                    rsp_chose_steady;

   // Predicted ratios in the order the requests were accepted.
   ratio_result_type expected_ratios [$];

   int error_count = 0;
   int cycle_count = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_cycles = 0;

   fm_protection_ratio_interp_top uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_wanted_freq_khz     (req_wanted_freq_khz),
      .req_interferer_freq_khz (req_interferer_freq_khz),
      .req_system_code         (req_system_code),
      .req_median_field        (req_median_field),
      .req_usable_field        (req_usable_field),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_protection_ratio    (rsp_protection_ratio),
      .rsp_chose_steady        (rsp_chose_steady)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Watchdog. The limit is far above the slowest legal run, so reaching
   // it means the block stopped returning results or stopped taking
   // requests.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver. A long hold-off, when one is requested, wins over the
   // random stall pattern and is counted down here one cycle at a time.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Interpolates one table row at the given offset. Past 400 kHz the last
   // segment is extended, and the value is clamped at -256 dB. Rounding is
   // to nearest with halves upward, through a floor division by 50.
   function automatic longint interp_row(input int row, input int unsigned offset);
      int unsigned seg;
      longint      lo;
      longint      hi;
      longint      num;
      longint      quot;
      seg = offset / GRID_KHZ;
      if (seg > LAST_SEG)
         seg = LAST_SEG;
      lo   = RATIO_TAB[row][seg];
      hi   = RATIO_TAB[row][seg + 1];
      num  = 2 * (hi - lo) * (longint'(offset) - longint'(seg) * GRID_KHZ) + GRID_KHZ;
      quot = num / (2 * GRID_KHZ);
      if ((num % (2 * GRID_KHZ)) != 0 && num < 0)
         quot -= 1;
      quot += lo;
      if (quot < RATIO_FLOOR)
         quot = RATIO_FLOOR;
      return quot;
   endfunction

   // Full prediction for one pair: offset, both ratios, then the choice.
   function automatic ratio_result_type predict_ratio(input carrier_pair_type pair);
      ratio_result_type res;
      int unsigned      offset;
      int               row;
      longint           steady;
      longint           tropo;
      offset = (pair.wanted >= pair.interferer) ? (pair.wanted - pair.interferer)
                                                : (pair.interferer - pair.wanted);
      case (pair.system_code)
         SYS_MONO75:                     row = ROW_MONO75;
         SYS_STEREO75:                   row = ROW_STEREO75;
         SYS_MONO50:                     row = ROW_MONO50;
         SYS_STEREO50, SYS_STEREO50_ALT: row = ROW_STEREO50;
         default:                        row = ROW_NONE;
      endcase
      steady = 0;
      tropo  = 0;
      if (row != ROW_NONE) begin
         steady = interp_row(row, offset);
         tropo  = interp_row(row + 1, offset);
      end
      res.steady = (longint'(pair.median) + steady) >= (tropo + longint'(pair.usable));
      res.ratio  = level_type'(res.steady ? steady : tropo);
      return res;
   endfunction

   function automatic carrier_pair_type make_pair(input int wanted, input int interferer,
                                                  input logic [SYS_W-1:0] code,
                                                  input int median, input int usable);
      carrier_pair_type pair;
      pair.wanted      = wanted[FREQ_W-1:0];
      pair.interferer  = interferer[FREQ_W-1:0];
      pair.system_code = code;
      pair.median      = level_type'(median);
      pair.usable      = level_type'(usable);
      return pair;
   endfunction

   // Random pair. Most offsets fall inside the table or just past it, some
   // reach the saturated region, and some use fully independent carriers.
   // Half the time the usable field sits close to the median field, so
   // that the steady/tropo choice actually depends on the ratios.
   function automatic carrier_pair_type random_pair();
      carrier_pair_type pair;
      int               offset;
      int               wanted;
      int               usable;
      int               pick;
      pick   = $urandom_range(0, 9);
      wanted = $urandom_range(0, FREQ_MAX);
      if (pick < 6)
         offset = $urandom_range(0, 450);
      else if (pick < 8)
         offset = $urandom_range(0, 4000);
      else if (pick < 9)
         offset = GRID_KHZ * $urandom_range(0, 17);
      else
         offset = -1;
      pair.wanted = wanted[FREQ_W-1:0];
      if (offset < 0) begin
         pair.interferer = FREQ_W'($urandom);
      end else if ((($urandom_range(0, 1) == 0) && wanted + offset <= FREQ_MAX)
                   || wanted < offset) begin
         pair.interferer = FREQ_W'(wanted + offset);
      end else begin
         pair.interferer = FREQ_W'(wanted - offset);
      end
      pair.system_code = SYS_W'($urandom);
      pair.median      = level_type'($urandom);
      if ($urandom_range(0, 1) == 0) begin
         usable = int'(pair.median) + $urandom_range(0, 400) - 200;
         if (usable > LEVEL_MAX)
            usable = LEVEL_MAX;
         if (usable < LEVEL_MIN)
            usable = LEVEL_MIN;
         pair.usable = level_type'(usable);
      end else begin
         pair.usable = level_type'($urandom);
      end
      return pair;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < MAX_PRINTED)
         $display("[%0d] mismatch in %s: got %0d, expected %0d", cycle_count, what, got,
                  want);
      error_count++;
   endtask

   // Sender. Random idle cycles come before the transfer, each one in its
   // own clock cycle, so valid is never lowered and raised in one step.
   // The prediction is queued at the edge where the transfer happens.
   task automatic send_pair(input carrier_pair_type pair);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_wanted_freq_khz     <= pair.wanted;
      req_interferer_freq_khz <= pair.interferer;
      req_system_code         <= pair.system_code;
      req_median_field        <= pair.median;
      req_usable_field        <= pair.usable;
      do
         @(posedge clock);
      while (req_stall);
      expected_ratios.push_back(predict_ratio(pair));
   endtask

   // Stops offering requests until every predicted result has come back.
   // The loop waits on the clock before it checks, so the lowered valid takes effect.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_ratios.size() != 0);
   endtask

   // Checker. Inputs change only through nonblocking assignments, so the
   // values seen here at the edge are the ones the block sampled.
   always @(posedge clock) begin
      ratio_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ratios.size() == 0) begin
            report_mismatch("unexpected result, ratio", rsp_protection_ratio, 0);
         end else begin
            want = expected_ratios.pop_front();
            if (rsp_protection_ratio !== want.ratio)
               report_mismatch("protection_ratio", rsp_protection_ratio, want.ratio);
            if (rsp_chose_steady !== want.steady)
               report_mismatch("chose_steady", rsp_chose_steady, want.steady);
         end
      end
   end

   // Corner cases: offset zero, rounding inside a segment, both ends of the
   // table, extrapolation past 400 kHz, saturation at -256 dB, the largest
   // possible offset, every system code including the unknown ones, field
   // extremes, and an exact tie in the steady/tropo comparison.
   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      send_pair(make_pair(0, 0, SYS_MONO75, 0, 0));
      send_pair(make_pair(FREQ_MAX, FREQ_MAX, SYS_STEREO75, LEVEL_MAX, LEVEL_MIN));
      send_pair(make_pair(0, FREQ_MAX, SYS_MONO50, LEVEL_MIN, LEVEL_MAX));
      send_pair(make_pair(FREQ_MAX, 0, SYS_STEREO50, 0, 0));
      send_pair(make_pair(100000, 100012, SYS_STEREO50_ALT, 100, 100));
      send_pair(make_pair(13, 0, SYS_MONO75, 50, 40));
      send_pair(make_pair(90000, 90375, SYS_MONO50, -20, 30));
      send_pair(make_pair(90400, 90000, SYS_STEREO75, 0, 0));
      send_pair(make_pair(50000, 50401, SYS_MONO75, 0, 0));
      send_pair(make_pair(51000, 50000, SYS_STEREO50, 0, 0));
      send_pair(make_pair(10000, 12760, SYS_MONO75, 0, 0));
      send_pair(make_pair(12800, 10000, SYS_MONO75, 0, 0));
      send_pair(make_pair(10000, 13000, SYS_MONO50, 0, 0));
      send_pair(make_pair(1000, 1100, SYS_UNKNOWN_ZERO, 300, 300));
      send_pair(make_pair(1000, 1100, SYS_UNKNOWN_ZERO, 299, 300));
      send_pair(make_pair(2000, 2050, SYS_UNKNOWN_SIX, LEVEL_MIN, LEVEL_MIN));
      send_pair(make_pair(FREQ_MAX, 3, SYS_UNKNOWN_SEVEN, LEVEL_MAX, LEVEL_MAX));
      // Offset zero, mono 75: steady 576, tropo 448. A difference of
      // exactly 128 between the fields is a tie and picks steady.
      send_pair(make_pair(7000, 7000, SYS_MONO75, 0, 128));
      send_pair(make_pair(7000, 7000, SYS_MONO75, 0, 129));
      send_pair(make_pair(7200, 7000, SYS_STEREO50_ALT, 10, 10));
      send_pair(make_pair(0, 0, SYS_STEREO50, LEVEL_MAX, LEVEL_MIN));
      wait_for_results();
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      for (int n = 0; n < count; n++)
         send_pair(random_pair());
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering requests back to back, so the pipeline fills and the block
   // must stall its input while the sender holds the request it cannot place.
   task automatic test_backpressure();
      idle_pct    = 0;
      stall_pct   = 0;
      hold_cycles = 300;
      for (int n = 0; n < 80; n++)
         send_pair(random_pair());
      wait_for_results();
   endtask

   // The sender stops until the block is empty, then resumes, several
   // times with light random stalls on both sides.
   task automatic test_sender_pause();
      idle_pct  = 20;
      stall_pct = 20;
      for (int round = 0; round < 3; round++) begin
         for (int n = 0; n < 15; n++)
            send_pair(random_pair());
         wait_for_results();
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(250, 0, 0);
      test_random(250, 50, 0);
      test_random(250, 0, 50);
      test_random(250, 11, 11);
      test_backpressure();
      test_sender_pause();

      // Everything predicted has arrived. The inputs then stay quiet so that a
      // stray extra result would still be caught.
      idle_pct  = 0;
      stall_pct = 0;
      req_valid <= 1'b0;
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (expected_ratios.size() != 0)
         report_mismatch("results left waiting", 0, expected_ratios.size());

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
